/* design/ptr_pkg.sv */
// shared types and constants for the paged translation core
package ptr_pkg;

  localparam int PROCESSES = 4;
  localparam int PAGES_PER_PROCESS = 64;
  localparam int FRAME_COUNT = 512;
  localparam int PID_BITS = 2;
  localparam int PAGE_BITS = 6;
  localparam int FRAME_BITS = 9;
  localparam int RES_BITS = 7;
  localparam logic [RES_BITS-1:0] FRAME_LIMIT_RESET = 7'd8;

  localparam int CFG_IDX_BITS = 8;
  localparam int CFG_DATA_BITS = 32;
  localparam logic [CFG_IDX_BITS-1:0] REG_REPLACEMENT_MODE = 8'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_MAX_FRAMES = 8'd1;
  localparam logic MODE_FIFO = 1'b0;
  localparam logic MODE_LRU = 1'b1;
  localparam logic STATUS_OK = 1'b0;
  localparam logic STATUS_NO_FRAME = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_DECIDE,
    ST_SCAN,
    ST_SCAN_LAST,
    ST_COMMIT
  } ctrl_state_t;

  typedef struct packed {
    logic latch;
    logic lookup;
    logic scan_start;
    logic scan_step;
    logic commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic hit;
    logic can_alloc;
    logic scan_done;
  } ctrl_status_t;

endpackage

/* design/paged_translation_with_replacement_core.sv */
// Top level of the paged translation core with local replacement.
// A hit or a free-frame fault goes through lookup, decide and commit; a fault that
// cannot allocate a frame also scans for a victim; one item at a time, busy while working.
// The victim scan reads one page entry per cycle.
// Synchronous reset clears residency, counters and the free frame pointer, and sets
// the config registers to their defaults; results cannot be stalled by the receiver.
module paged_translation_with_replacement_core import ptr_pkg::*; #(
  parameter int OFFSET_BITS = 6,
  parameter int TIME_BITS = 32
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic [PID_BITS-1:0]      proc_id,
  input  logic [PAGE_BITS-1:0]     page,
  input  logic [OFFSET_BITS-1:0]   offset,
  output logic                     result_valid,
  output logic                     hit,
  output logic [FRAME_BITS-1:0]    frame,
  output logic [OFFSET_BITS-1:0]   physical_offset,
  output logic                     evicted_valid,
  output logic [PAGE_BITS-1:0]     evicted_page,
  output logic [RES_BITS-1:0]      resident_count,
  output logic                     status,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data
);

  ctrl_cmd_t           cmd;
  ctrl_status_t        stat;
  logic                mode;
  logic [RES_BITS-1:0] frame_limit;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_FIFO;
      frame_limit <= FRAME_LIMIT_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_REPLACEMENT_MODE: mode <= cfg_data[0];
        REG_MAX_FRAMES: frame_limit <= cfg_data[RES_BITS-1:0];
        default: ;
      endcase
    end
  end

  ptr_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .stat(stat), .cmd(cmd), .busy(busy)
  );

  ptr_datapath #(
    .OFFSET_BITS(OFFSET_BITS), .TIME_BITS(TIME_BITS)
  ) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat), .cfg_mode(mode),
    .cfg_max(frame_limit), .proc_id(proc_id), .page(page), .offset(offset),
    .done(result_valid), .hit(hit), .frame(frame),
    .physical_offset(physical_offset), .evicted_valid(evicted_valid),
    .evicted_page(evicted_page), .resident_count(resident_count), .status(status)
  );

endmodule

/* design/ptr_ctrl.sv */
// controller state machine sequencing lookup, victim scan and commit
module ptr_ctrl import ptr_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  ctrl_status_t stat,
  output ctrl_cmd_t    cmd,
  output logic         busy
);

  ctrl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start) state_next = ST_LOOKUP;
      end
      ST_LOOKUP: state_next = ST_DECIDE;
      ST_DECIDE: begin
        if (stat.hit || stat.can_alloc) state_next = ST_COMMIT;
        else state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (stat.scan_done) state_next = ST_SCAN_LAST;
      end
      ST_SCAN_LAST: state_next = ST_COMMIT;
      ST_COMMIT: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    busy = (state != ST_IDLE);
    case (state)
      ST_IDLE: cmd.latch = start;
      ST_LOOKUP: cmd.lookup = 1'b1;
      ST_DECIDE: cmd.scan_start = !(stat.hit || stat.can_alloc);
      ST_SCAN: cmd.scan_step = 1'b1;
      ST_SCAN_LAST: cmd.scan_step = 1'b1;
      ST_COMMIT: cmd.commit = 1'b1;
      default: cmd = '0;
    endcase
  end

endmodule

/* design/ptr_datapath.sv */
// page tables, free frame pointer, victim scan and result registers
module ptr_datapath import ptr_pkg::*; #(
  parameter int OFFSET_BITS = 6,
  parameter int TIME_BITS = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  ctrl_cmd_t              cmd,
  output ctrl_status_t           stat,
  input  logic                   cfg_mode,
  input  logic [RES_BITS-1:0]    cfg_max,
  input  logic [PID_BITS-1:0]    proc_id,
  input  logic [PAGE_BITS-1:0]   page,
  input  logic [OFFSET_BITS-1:0] offset,
  output logic                   done,
  output logic                   hit,
  output logic [FRAME_BITS-1:0]  frame,
  output logic [OFFSET_BITS-1:0] physical_offset,
  output logic                   evicted_valid,
  output logic [PAGE_BITS-1:0]   evicted_page,
  output logic [RES_BITS-1:0]    resident_count,
  output logic                   status
);

  localparam int ENTRIES = PROCESSES * PAGES_PER_PROCESS;
  localparam int ENTRY_BITS = PID_BITS + PAGE_BITS;
  localparam int PIDX_BITS = (PROCESSES > 1) ? $clog2(PROCESSES) : 1;
  localparam int FCNT_BITS = $clog2(FRAME_COUNT + 1);
  localparam logic [TIME_BITS-1:0] TIME_MAX = '1;

  logic [FRAME_BITS-1:0] mem_frame [ENTRIES];
  logic [TIME_BITS-1:0]  mem_loaded [ENTRIES];
  logic [TIME_BITS-1:0]  mem_used [ENTRIES];
  logic [ENTRIES-1:0]    present;

  logic [FCNT_BITS-1:0]  free_count;
  logic [FRAME_BITS-1:0] free_head;
  logic [TIME_BITS-1:0]  access_time;
  logic [RES_BITS-1:0]   resident [PROCESSES];
  logic [31:0]           faults [PROCESSES];
  logic [31:0]           accesses [PROCESSES];

  logic [PIDX_BITS-1:0]   cur_pid;
  logic [PAGE_BITS-1:0]   cur_page;
  logic [OFFSET_BITS-1:0] cur_off;
  logic                   cur_hit;
  logic                   cur_alloc;
  logic [FRAME_BITS-1:0]  rd_frame;
  logic [TIME_BITS-1:0]   rd_key;
  logic [PAGE_BITS:0]     scan_idx;
  logic [PAGE_BITS-1:0]   key_page;
  logic                   key_valid;
  logic                   best_valid;
  logic [PAGE_BITS-1:0]   best_page;
  logic [TIME_BITS-1:0]   best_key;
  logic [FRAME_BITS-1:0]  best_frame;

  logic [ENTRY_BITS-1:0] cur_entry;
  logic [ENTRY_BITS-1:0] scan_entry;
  logic [ENTRY_BITS-1:0] rd_addr;
  logic [PIDX_BITS-1:0]  in_pid;
  logic [PAGE_BITS-1:0]  in_page;

  assign in_pid = PIDX_BITS'(proc_id % PROCESSES);
  assign in_page = PAGE_BITS'(page % PAGES_PER_PROCESS);
  assign cur_entry = ENTRY_BITS'(cur_pid) * ENTRY_BITS'(PAGES_PER_PROCESS)
                   + ENTRY_BITS'(cur_page);
  assign scan_entry = ENTRY_BITS'(cur_pid) * ENTRY_BITS'(PAGES_PER_PROCESS)
                    + ENTRY_BITS'(scan_idx[PAGE_BITS-1:0]);
  assign rd_addr = cmd.scan_step ? scan_entry : cur_entry;

  assign stat.hit = cur_hit;
  assign stat.can_alloc = cur_alloc;
  assign stat.scan_done = (scan_idx == (PAGE_BITS+1)'(PAGES_PER_PROCESS - 1));

  // registered reads, one port for frame and one for the victim key
  always_ff @(posedge clk) begin
    rd_frame <= mem_frame[rd_addr];
    rd_key <= (cfg_mode == MODE_LRU) ? mem_used[rd_addr] : mem_loaded[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      cur_pid <= in_pid;
      cur_page <= in_page;
      cur_off <= offset;
    end
    if (cmd.lookup) begin
      cur_hit <= present[cur_entry];
      cur_alloc <= (7'(resident[cur_pid]) < cfg_max) && (free_count != '0);
    end
    if (cmd.scan_start) begin
      scan_idx <= '0;
    end else if (cmd.scan_step && !stat.scan_done) begin
      scan_idx <= scan_idx + 1'b1;
    end
    key_page <= scan_idx[PAGE_BITS-1:0];
    key_valid <= cmd.scan_step && present[scan_entry];
  end

  // running minimum over the entries read in the previous cycle
  always_ff @(posedge clk) begin
    if (rst || cmd.scan_start) begin
      best_valid <= 1'b0;
    end else if (key_valid && (!best_valid || rd_key < best_key)) begin
      best_valid <= 1'b1;
    end
    if (key_valid && (!best_valid || rd_key < best_key)) begin
      best_key <= rd_key;
      best_page <= key_page;
      best_frame <= rd_frame;
    end
  end

  logic [ENTRY_BITS-1:0] victim_entry;
  logic [FRAME_BITS-1:0] new_frame;
  logic                  loaded;
  assign victim_entry = ENTRY_BITS'(cur_pid) * ENTRY_BITS'(PAGES_PER_PROCESS)
                      + ENTRY_BITS'(best_page);
  assign new_frame = cur_alloc ? free_head : best_frame;
  assign loaded = !cur_hit && (cur_alloc || best_valid);

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      if (cur_hit) begin
        mem_used[cur_entry] <= access_time;
      end else if (loaded) begin
        mem_frame[cur_entry] <= new_frame;
        mem_loaded[cur_entry] <= access_time;
        mem_used[cur_entry] <= access_time;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      present <= '0;
      free_count <= FCNT_BITS'(FRAME_COUNT);
      free_head <= '0;
      access_time <= '0;
      done <= 1'b0;
      for (int i = 0; i < PROCESSES; i++) begin
        resident[i] <= '0;
        faults[i] <= '0;
        accesses[i] <= '0;
      end
    end else begin
      done <= cmd.commit;
      if (cmd.commit) begin
        if (access_time != TIME_MAX) access_time <= access_time + 1'b1;
        if (accesses[cur_pid] != '1) accesses[cur_pid] <= accesses[cur_pid] + 1'b1;
        if (!cur_hit) begin
          if (faults[cur_pid] != '1) faults[cur_pid] <= faults[cur_pid] + 1'b1;
          if (cur_alloc) begin
            free_count <= free_count - 1'b1;
            free_head <= (free_head == FRAME_BITS'(FRAME_COUNT - 1)) ? '0
                       : free_head + 1'b1;
            resident[cur_pid] <= resident[cur_pid] + 1'b1;
            present[cur_entry] <= 1'b1;
          end else if (best_valid) begin
            present[victim_entry] <= 1'b0;
            present[cur_entry] <= 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      hit <= cur_hit;
      frame <= cur_hit ? rd_frame : (loaded ? new_frame : '0);
      physical_offset <= cur_off;
      evicted_valid <= !cur_hit && !cur_alloc && best_valid;
      evicted_page <= (!cur_hit && !cur_alloc && best_valid) ? best_page : '0;
      resident_count <= (!cur_hit && cur_alloc) ? resident[cur_pid] + 1'b1
                                                : resident[cur_pid];
      status <= loaded || cur_hit ? STATUS_OK : STATUS_NO_FRAME;
    end
  end

endmodule

/* design/ptr_checker.sv */
// port-level checks for the paged translation core
module ptr_checker (
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic       result_valid,
  input logic       hit,
  input logic       evicted_valid,
  input logic       status
);

  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy) else $error("item not taken");
  a_result_ends: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !busy) else $error("result while busy");
  a_hit_no_evict: assert property (@(posedge clk) disable iff (rst)
    result_valid && hit |-> !evicted_valid && !status) else $error("bad hit");
  a_err_no_evict: assert property (@(posedge clk) disable iff (rst)
    result_valid && status |-> !evicted_valid && !hit) else $error("bad status");
  a_single: assert property (@(posedge clk) disable iff (rst)
    result_valid |=> !result_valid) else $error("double result");

endmodule

bind paged_translation_with_replacement_core ptr_checker u_chk (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .result_valid(result_valid),
  .hit(hit), .evicted_valid(evicted_valid), .status(status)
);
